// File: rtl/rc4ks_pkg.sv
// rc4ks_pkg: shared types, constants and the key byte selector for the rc4 keystream block
// used by rc4ks_ram and rc4_keystream_cipher; depends on nothing
`default_nettype none

package rc4ks_pkg;

   localparam int unsigned PERM_DEPTH = 256;
   localparam int unsigned ADDR_W     = 8;
   localparam int unsigned KEY_W      = 64;
   localparam int unsigned CSR_IDX_W  = 2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MODE = 2'd2;

   // item kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // pad bytes of the short key, key positions 5, 6 and 7
   localparam logic [7:0] PAD_BYTE_5 = 8'he5;
   localparam logic [7:0] PAD_BYTE_6 = 8'h38;
   localparam logic [7:0] PAD_BYTE_7 = 8'hb0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD_N,
      ST_KS_RD_J,
      ST_KS_WR_N,
      ST_KS_WR_J,
      ST_KS_DONE,
      ST_DT_RD_I,
      ST_DT_RD_J,
      ST_DT_WR_I,
      ST_DT_WR_J,
      ST_DT_OUT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   // key byte for schedule step n (only the low four bits of n matter)
   function automatic logic [7:0] key_byte(input logic             short_mode,
                                           input logic [KEY_W-1:0] key_lo,
                                           input logic [KEY_W-1:0] key_hi,
                                           input logic [3:0]       n);
      logic [7:0] b_lo;
      logic [7:0] b_hi;
      logic [7:0] r;
      b_lo = key_lo[{n[2:0], 3'b000} +: 8];
      b_hi = key_hi[{n[2:0], 3'b000} +: 8];
      if (short_mode) begin
         case (n[2:0])
            3'd5:    r = PAD_BYTE_5;
            3'd6:    r = PAD_BYTE_6;
            3'd7:    r = PAD_BYTE_7;
            default: r = b_lo;
         endcase
      end else begin
         r = n[3] ? b_hi : b_lo;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/rc4_keystream_cipher.sv
// rc4_keystream_cipher: top level, sequencer around one permutation ram
// depends on rc4ks_pkg and rc4ks_ram
`default_nettype none

// RC4 engine. A key beat (kind 0) fills the permutation with identity, one entry a
// cycle, then runs the 256 key schedule swaps, and returns one beat with out_byte
// zero. A data beat (kind 1) does one keystream step and returns data xor keystream.
// In both cases the next beat is taken only once the engine is back in idle, after
// the result has been registered. The sequencing comes from the single write and
// single read port of the permutation ram: a swap step needs two reads and two
// writes in sequence, and a data step adds the keystream read. req_ready is high
// only while the engine is idle; a finished result waits in the output register and
// does not block the next accept, but the next result is held back until it has
// been taken. Key registers are sampled during the schedule, so they must be
// written before the key beat. Data beats must follow a key beat.
module rc4_keystream_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   // item input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_out,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   rc4ks_pkg::state_type   state_ff, state_in;
   logic [7:0]             n_ff, n_in;
   logic [7:0]             i_ff, i_in;
   logic [7:0]             j_ff, j_in;
   logic [7:0]             si_ff, si_in;
   logic [7:0]             sj_ff, sj_in;
   logic [7:0]             data_ff, data_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [63:0]            key_low_ff;
   logic [63:0]            key_high_ff;
   logic                   short_mode_ff;

   rc4ks_pkg::ram_req_type ram_req;
   logic [7:0]             rd_data;
   logic [7:0]             kbyte;
   logic [7:0]             i_next;
   logic [7:0]             j_ks_next;
   logic [7:0]             j_dt_next;
   logic                   out_free;

   rc4ks_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   // configuration registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         short_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            rc4ks_pkg::CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            rc4ks_pkg::CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            rc4ks_pkg::CSR_SHORT_MODE: short_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign kbyte     = rc4ks_pkg::key_byte(short_mode_ff, key_low_ff, key_high_ff, n_ff[3:0]);
   assign i_next    = i_ff + 8'd1;
   assign j_ks_next = j_ff + rd_data + kbyte;
   assign j_dt_next = j_ff + rd_data;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4ks_pkg::ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      ram_req      = '0;
      req_ready    = 1'b0;

      case (state_ff)
         rc4ks_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               data_in = req_data_byte;
               last_in = req_last_byte;
               if (req_kind == rc4ks_pkg::KIND_KEY) begin
                  n_in     = '0;
                  j_in     = '0;
                  state_in = rc4ks_pkg::ST_INIT;
               end else begin
                  state_in = rc4ks_pkg::ST_DT_RD_I;
               end
            end
         end
         // identity fill, one entry a cycle
         rc4ks_pkg::ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = n_ff;
            n_in          = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               state_in = rc4ks_pkg::ST_KS_RD_N;
            end
         end
         rc4ks_pkg::ST_KS_RD_N: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = n_ff;
            state_in      = rc4ks_pkg::ST_KS_RD_J;
         end
         rc4ks_pkg::ST_KS_RD_J: begin
            si_in         = rd_data;
            j_in          = j_ks_next;
            ram_req.re    = 1'b1;
            ram_req.raddr = j_ks_next;
            state_in      = rc4ks_pkg::ST_KS_WR_N;
         end
         rc4ks_pkg::ST_KS_WR_N: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = rd_data;
            state_in      = rc4ks_pkg::ST_KS_WR_J;
         end
         rc4ks_pkg::ST_KS_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            n_in          = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               i_in     = '0;
               j_in     = '0;
               state_in = rc4ks_pkg::ST_KS_DONE;
            end else begin
               state_in = rc4ks_pkg::ST_KS_RD_N;
            end
         end
         rc4ks_pkg::ST_KS_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_last_in  = last_ff;
               state_in     = rc4ks_pkg::ST_IDLE;
            end
         end
         rc4ks_pkg::ST_DT_RD_I: begin
            i_in          = i_next;
            ram_req.re    = 1'b1;
            ram_req.raddr = i_next;
            state_in      = rc4ks_pkg::ST_DT_RD_J;
         end
         rc4ks_pkg::ST_DT_RD_J: begin
            si_in         = rd_data;
            j_in          = j_dt_next;
            ram_req.re    = 1'b1;
            ram_req.raddr = j_dt_next;
            state_in      = rc4ks_pkg::ST_DT_WR_I;
         end
         rc4ks_pkg::ST_DT_WR_I: begin
            sj_in         = rd_data;
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = rd_data;
            state_in      = rc4ks_pkg::ST_DT_WR_J;
         end
         // second swap write and keystream read share the cycle, ram forwards
         rc4ks_pkg::ST_DT_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            ram_req.re    = 1'b1;
            ram_req.raddr = si_ff + sj_ff;
            state_in      = rc4ks_pkg::ST_DT_OUT;
         end
         rc4ks_pkg::ST_DT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ rd_data;
               rsp_last_in  = last_ff;
               state_in     = rc4ks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rc4ks_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/rc4ks_ram.sv
// rc4ks_ram: 256 x 8 permutation store, one write and one read port, registered read
// depends on rc4ks_pkg for the request struct
`default_nettype none

module rc4ks_ram (
   input  wire logic                 clock,
   input  wire rc4ks_pkg::ram_req_type req,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [rc4ks_pkg::PERM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
   end

   // write-first: a read of the address being written returns the new byte
   always_ff @(posedge clock) begin
      if (req.re) begin
         if (req.we && (req.waddr == req.raddr)) begin
            rd_data_ff <= req.wdata;
         end else begin
            rd_data_ff <= mem[req.raddr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rc4ks_checker.sv
// rc4ks_checker: port-level assertions for rc4_keystream_cipher, bound to the top level
// depends only on the top level's ports
`default_nettype none

module rc4ks_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_out,
   input wire logic       csr_ready
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_out))
      else $error("result beat changed while stalled");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // an item's result never comes right behind its accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after accept");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind rc4_keystream_cipher rc4ks_checker u_rc4ks_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last_out (rsp_last_out),
   .csr_ready    (csr_ready)
);

`default_nettype wire

// File: test/tb_rc4_keystream_cipher.sv
// tb_rc4_keystream_cipher: self-checking bench for the rc4 keystream block
// holds its own rc4 schedule/keystream predictor and checks every result beat in order
// depends on rc4ks_pkg and the rc4_keystream_cipher rtl
`timescale 1ns / 1ps

module tb_rc4_keystream_cipher;

   localparam logic [rc4ks_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEM_TARGET = 1700;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       last_byte;
   } rc4_cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
   } cipher_result_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_kind      = rc4ks_pkg::KIND_KEY;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_out;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index     = rc4ks_pkg::CSR_KEY_LOW;
   logic [63:0] csr_wdata     = 64'h0;

   rc4_keystream_cipher DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_out  (rsp_last_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [7:0]  perm_model [0:255];
   logic [7:0]  ks_i;
   logic [7:0]  ks_j;
   logic [63:0] model_key_low    = 64'h0;
   logic [63:0] model_key_high   = 64'h0;
   logic        model_short_mode = 1'b1;

   rc4_cmd_type       rc4_cmd_q [$];
   cipher_result_type cipher_results_q [$];

   bit drv_idle_on = 1'b0;
   bit mon_idle_on = 1'b0;
   int feed_gap    = 0;
   int drain_stall = 0;
   int fail_count  = 0;
   int n_queued    = 0;
   int n_items     = 0;
   int n_key_sched = 0;
   int n_results   = 0;
   int n_csr_writes = 0;
   int cycle_count = 0;

   task automatic schedule_key();
      logic [7:0] kb [0:15];
      logic [7:0] j;
      logic [7:0] t;
      for (int n = 0; n < 8; n++) begin
         kb[n]     = model_key_low[8*n +: 8];
         kb[n + 8] = model_key_high[8*n +: 8];
      end
      if (model_short_mode) begin
         // 40-bit key, padded to 8 bytes and repeated
         kb[5] = rc4ks_pkg::PAD_BYTE_5;
         kb[6] = rc4ks_pkg::PAD_BYTE_6;
         kb[7] = rc4ks_pkg::PAD_BYTE_7;
         for (int n = 8; n < 16; n++)
            kb[n] = kb[n - 8];
      end
      for (int n = 0; n < 256; n++)
         perm_model[n] = 8'(n);
      j = 8'h00;
      for (int n = 0; n < 256; n++) begin
         j = j + perm_model[n] + kb[n % 16];
         t = perm_model[n];
         perm_model[n] = perm_model[j];
         perm_model[j] = t;
      end
      ks_i = 8'h00;
      ks_j = 8'h00;
   endtask

   task automatic step_keystream(output logic [7:0] ks);
      logic [7:0] t;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + perm_model[ks_i];
      t = perm_model[ks_i];
      perm_model[ks_i] = perm_model[ks_j];
      perm_model[ks_j] = t;
      t = perm_model[ks_i] + perm_model[ks_j];
      ks = perm_model[t];
   endtask

   task automatic predict_beat(input logic kind, input logic [7:0] data, input logic last);
      cipher_result_type r;
      logic [7:0]        ks;
      if (kind == rc4ks_pkg::KIND_KEY) begin
         schedule_key();
         r.out_byte = 8'h00;
         n_key_sched++;
      end else begin
         step_keystream(ks);
         r.out_byte = data ^ ks;
      end
      r.last_out = last;
      cipher_results_q.push_back(r);
      n_items++;
   endtask

   // register shadow, updated on each accepted csr beat
   always @(posedge clock) begin
      if (reset) begin
         model_key_low    <= 64'h0;
         model_key_high   <= 64'h0;
         model_short_mode <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rc4ks_pkg::CSR_KEY_LOW:    model_key_low    <= csr_wdata;
            rc4ks_pkg::CSR_KEY_HIGH:   model_key_high   <= csr_wdata;
            rc4ks_pkg::CSR_SHORT_MODE: model_short_mode <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   // request driver
   always @(posedge clock) begin
      rc4_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap  = 0;
      end else begin
         if (req_valid && req_ready)
            predict_beat(req_kind, req_data_byte, req_last_byte);
         if (!req_valid || req_ready) begin
            if (feed_gap != 0) begin
               req_valid <= 1'b0;
               feed_gap  = feed_gap - 1;
            end else if (rc4_cmd_q.size() != 0) begin
               nxt = rc4_cmd_q.pop_front();
               req_valid     <= 1'b1;
               req_kind      <= nxt.kind;
               req_data_byte <= nxt.data_byte;
               req_last_byte <= nxt.last_byte;
               feed_gap = drv_idle_on ? $urandom_range(0, 7) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      cipher_result_type want;
      if (reset) begin
         rsp_ready   <= 1'b0;
         drain_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (cipher_results_q.size() == 0) begin
               $error("result beat with nothing pending: out_byte %0h last_out %0b",
                      rsp_out_byte, rsp_last_out);
               fail_count++;
            end else begin
               want = cipher_results_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_last_out);
                  fail_count++;
               end
            end
            drain_stall = mon_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (drain_stall != 0) begin
            rsp_ready   <= 1'b0;
            drain_stall = drain_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_cmd(input logic kind, input logic [7:0] data, input logic last);
      rc4_cmd_type c;
      c.kind      = kind;
      c.data_byte = data;
      c.last_byte = last;
      rc4_cmd_q.push_back(c);
      n_queued++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_csr_writes++;
   endtask

   // block is idle once every queued beat was accepted and every result came back
   task automatic wait_quiet();
      while (n_items != n_queued || cipher_results_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] rand_key64();
      case ($urandom_range(0, 5))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int len;
      logic kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: all-zero short key
      push_cmd(rc4ks_pkg::KIND_KEY, 8'hff, 1'b1);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h00, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'hff, 1'b1);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'ha5, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h5a, 1'b1);
      wait_quiet();

      // full 16 byte key, all ones
      csr_write(rc4ks_pkg::CSR_KEY_LOW, '1);
      csr_write(rc4ks_pkg::CSR_KEY_HIGH, '1);
      csr_write(rc4ks_pkg::CSR_SHORT_MODE, 64'h0);
      push_cmd(rc4ks_pkg::KIND_KEY, 8'h00, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h00, 1'b1);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'hff, 1'b0);
      push_cmd(rc4ks_pkg::KIND_KEY, 8'h3c, 1'b1);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h01, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h80, 1'b1);
      wait_quiet();

      // new key written mid-stream: old permutation stays until the next key beat
      csr_write(rc4ks_pkg::CSR_KEY_LOW, 64'h0123_4567_89ab_cdef);
      csr_write(rc4ks_pkg::CSR_SHORT_MODE, 64'hffff_ffff_ffff_ffff);
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h7e, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h81, 1'b0);
      push_cmd(rc4ks_pkg::KIND_KEY, 8'h00, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'h00, 1'b0);
      push_cmd(rc4ks_pkg::KIND_DATA, 8'hff, 1'b1);
      wait_quiet();

      while (n_queued < ITEM_TARGET) begin
         drv_idle_on = ($urandom_range(0, 3) != 0);
         mon_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) != 0)
            csr_write(rc4ks_pkg::CSR_KEY_LOW, rand_key64());
         if ($urandom_range(0, 2) != 0)
            csr_write(rc4ks_pkg::CSR_KEY_HIGH, rand_key64());
         if ($urandom_range(0, 1) != 0)
            csr_write(rc4ks_pkg::CSR_SHORT_MODE, {$urandom, $urandom});
         if ($urandom_range(0, 9) == 0)
            csr_write(CSR_UNUSED, {$urandom, $urandom});
         if ($urandom_range(0, 4) != 0)
            push_cmd(rc4ks_pkg::KIND_KEY, 8'($urandom), 1'($urandom));
         // long streams wrap the i index
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 320) : $urandom_range(1, 80);
         for (int k = 0; k < len; k++) begin
            kind = ($urandom_range(0, 49) == 0) ? rc4ks_pkg::KIND_KEY : rc4ks_pkg::KIND_DATA;
            push_cmd(kind, 8'($urandom), 1'($urandom));
         end
         wait_quiet();
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      $display("%0d beats in (%0d key schedules), %0d results checked, %0d register writes",
               n_items, n_key_sched, n_results, n_csr_writes);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/rc4ks_pkg.sv
rtl/rc4ks_ram.sv
rtl/rc4_keystream_cipher.sv
rtl/rc4ks_checker.sv
test/tb_rc4_keystream_cipher.sv
